### src/msbrs_pkg.sv
// msbrs_pkg: widths, limits, state type and step control struct for the
// bounded-run maximum subset sum block. No dependencies.
package msbrs_pkg;

  localparam int VALUE_W = 31;
  localparam int SUM_W   = 63;
  localparam int CFG_W   = 7;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_INIT,
    ST_LOOP,
    ST_FINISH
  } state_t;

  // control from the sequencer to the accumulate step
  typedef struct packed {
    logic init;           // clear run sum, load starting best
    logic init_use_hist;  // starting best comes from the newest stored optimum
    logic sat_init;       // sticky saturation carried in from the sequence
    logic step;           // fold one run length into the best
    logic first;          // run length one, value comes from the held item
    logic use_prev;       // older optimum exists for this run length
  } step_ctl_t;

endpackage

### src/msbrs_if.sv
// msbrs_if: valid/ready channel interfaces for item, result and config.
// Depends on msbrs_pkg.
interface msbrs_item_if
  import msbrs_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               start_req;

  modport source (output valid, output value, output start_req, input ready);
  modport sink   (input valid, input value, input start_req, output ready);
endinterface

interface msbrs_result_if
  import msbrs_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] best_sum;
  logic             saturated;

  modport source (output valid, output best_sum, output saturated, input ready);
  modport sink   (input valid, input best_sum, input saturated, output ready);
endinterface

interface msbrs_cfg_if
  import msbrs_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] max_run;

  modport source (output valid, output max_run, input ready);
  modport sink   (input valid, input max_run, output ready);
endinterface

### src/msbrs_ram.sv
// msbrs_ram: generic single-write, single-read ram with registered read.
// No dependencies.
module msbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/msbrs_step.sv
// msbrs_step: run-sum accumulator, candidate add, saturation and best tracking.
// Depends on msbrs_pkg.
module msbrs_step
  import msbrs_pkg::*;
#(
  parameter int MAX_RUN = 64
) (
  input  logic               clk,
  input  step_ctl_t          ctl,
  input  logic [VALUE_W-1:0] cur_value,
  input  logic [VALUE_W-1:0] old_value,
  input  logic [SUM_W-1:0]   hist_best,
  output logic [SUM_W-1:0]   final_best,
  output logic               final_sat
);

  localparam int RW = VALUE_W + $clog2(MAX_RUN + 1);

  logic [RW-1:0]    run_r;
  logic [SUM_W-1:0] best_r;
  logic             sat_r;

  logic [VALUE_W-1:0] val_t;
  logic [RW-1:0]      run_nxt;
  logic [SUM_W:0]     cand;
  logic [SUM_W-1:0]   cand_clamp;

  always_comb begin
    val_t      = ctl.first ? cur_value : old_value;
    run_nxt    = run_r + RW'(val_t);
    // one extra bit catches overflow past the largest sum
    cand       = (SUM_W+1)'(run_nxt) + (ctl.use_prev ? {1'b0, hist_best} : '0);
    cand_clamp = cand[SUM_W] ? SUM_MAX : cand[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      run_r  <= '0;
      best_r <= ctl.init_use_hist ? hist_best : '0;
      sat_r  <= ctl.sat_init;
    end else if (ctl.step) begin
      run_r <= run_nxt;
      sat_r <= sat_r | cand[SUM_W];
      if (cand_clamp > best_r) begin
        best_r <= cand_clamp;
      end
    end
  end

  assign final_best = sat_r ? SUM_MAX : best_r;
  assign final_sat  = sat_r;

endmodule

### src/max_sum_bounded_run_select.sv
// max_sum_bounded_run_select: top level, sequencer, value and optimum rams.
// Depends on msbrs_pkg, msbrs_if, msbrs_ram and msbrs_step.
//
// usage
// - in_if carries one value per transaction, start_req opens a new sequence;
//   the first item after reset opens one as well
// - out_if returns one transaction per item: the best sum of a subset of the
//   prefix with at most max_run adjacent picks, plus a sticky clamp flag
// - cfg_if writes max_run (0 acts as 1, above MAX_RUN acts as MAX_RUN);
//   it is ready out of reset and the new bound applies from the next item on
// - an item goes through an accept step, an init step that loads the newest
//   stored optimum, a loop over n run lengths with n = min(max_run, items so
//   far in the sequence) that walks the value and optimum rams (one read
//   each per cycle through one adder and comparator), and a finish step that
//   writes the new optimum back
// - one item is in work at a time; in_if is ready only when idle and out of reset
// - the result sits in an output register; a new item is accepted while it
//   waits, and the block holds in its finish cycle only if the previous
//   result is still not taken
// - reset clears the sequencer, the position and the saturation flag; the
//   ram contents are left as they are and only entries of the current
//   sequence are ever used
module max_sum_bounded_run_select
  import msbrs_pkg::*;
#(
  parameter int MAX_RUN = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  msbrs_item_if.sink     in_if,
  msbrs_result_if.source out_if,
  msbrs_cfg_if.sink      cfg_if
);

  localparam int VDEPTH = MAX_RUN;
  localparam int HDEPTH = MAX_RUN + 1;
  localparam int VAW    = (VDEPTH > 1) ? $clog2(VDEPTH) : 1;
  localparam int HAW    = $clog2(HDEPTH);
  localparam int PW     = $clog2(MAX_RUN + 3);
  localparam int CW     = (PW > CFG_W) ? PW : CFG_W;

  localparam logic [VAW-1:0] VLAST   = VAW'(VDEPTH - 1);
  localparam logic [HAW-1:0] HLAST   = HAW'(HDEPTH - 1);
  localparam logic [PW-1:0]  POS_TOP = PW'(MAX_RUN + 2);

  // sequencer state
  state_t state_r, state_nxt;

  logic [CFG_W-1:0]   max_run_r;
  logic [PW-1:0]      pos_r;
  logic               sat_seen_r;
  logic [VALUE_W-1:0] v_r;
  logic [PW-1:0]      n_r;
  logic [PW-1:0]      t_r;

  // ram pointers: newest written slot and walking read address
  logic [VAW-1:0] vnew_r, vrd_r;
  logic [HAW-1:0] hnew_r, hrd_r;

  // output register
  logic             out_valid_r;
  logic [SUM_W-1:0] out_sum_r;
  logic             out_sat_r;

  logic               accept;
  logic               finish_go;
  logic               loop_last;
  logic [VAW-1:0]     vwr;
  logic [VAW-1:0]     vrd_dec;
  logic [HAW-1:0]     hwr;
  logic [HAW-1:0]     hnew_dec;
  logic [HAW-1:0]     hrd_dec;
  logic [HAW-1:0]     hraddr;
  logic [PW-1:0]      pos_new;
  logic [CW-1:0]      mr_ext;
  logic [CW-1:0]      keff;
  logic [CW-1:0]      n_new;
  logic [VALUE_W-1:0] vdata;
  logic [SUM_W-1:0]   hdata;
  logic [SUM_W-1:0]   fin_best;
  logic               fin_sat;
  step_ctl_t          ctl;

  // pointer arithmetic with wrap
  always_comb begin
    vwr      = (vnew_r == VLAST) ? '0 : vnew_r + VAW'(1);
    vrd_dec  = (vrd_r == '0) ? VLAST : vrd_r - VAW'(1);
    hwr      = (hnew_r == HLAST) ? '0 : hnew_r + HAW'(1);
    hnew_dec = (hnew_r == '0) ? HLAST : hnew_r - HAW'(1);
    hrd_dec  = (hrd_r == '0) ? HLAST : hrd_r - HAW'(1);
  end

  // position of the incoming item and the number of run lengths to try
  always_comb begin
    if (in_if.start_req) begin
      pos_new = PW'(1);
    end else if (pos_r < POS_TOP) begin
      pos_new = pos_r + PW'(1);
    end else begin
      pos_new = pos_r;
    end
    mr_ext = CW'(max_run_r);
    if (mr_ext == '0) begin
      keff = CW'(1);
    end else if (mr_ext > CW'(MAX_RUN)) begin
      keff = CW'(MAX_RUN);
    end else begin
      keff = mr_ext;
    end
    n_new = (keff < CW'(pos_new)) ? keff : CW'(pos_new);
  end

  assign accept    = in_if.valid && in_if.ready;
  assign finish_go = !out_valid_r || out_if.ready;
  assign loop_last = (t_r == n_r - PW'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = ST_INIT;
        end
      end
      ST_INIT: begin
        state_nxt = ST_LOOP;
      end
      ST_LOOP: begin
        if (loop_last) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_if.ready       = 1'b0;
    hraddr            = hrd_r;
    ctl               = '0;
    ctl.init_use_hist = (pos_r >= PW'(2));
    ctl.sat_init      = sat_seen_r;
    ctl.first         = (t_r == '0);
    // an older optimum exists when position >= run length + 2
    ctl.use_prev      = ((PW+1)'(pos_r) >= (PW+1)'(t_r) + (PW+1)'(3));
    unique case (state_r)
      ST_IDLE: begin
        in_if.ready = rst_n;     // no transaction is taken while in reset
        hraddr      = hnew_r;    // newest optimum, used in the init cycle
      end
      ST_INIT: begin
        ctl.init = 1'b1;
      end
      ST_LOOP: begin
        ctl.step = 1'b1;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      max_run_r   <= CFG_W'(1);
      pos_r       <= '0;
      sat_seen_r  <= 1'b0;
      n_r         <= '0;
      t_r         <= '0;
      vnew_r      <= '0;
      vrd_r       <= '0;
      hnew_r      <= '0;
      hrd_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_if.valid) begin
        max_run_r <= cfg_if.max_run;
      end
      if (accept) begin
        pos_r      <= pos_new;
        sat_seen_r <= in_if.start_req ? 1'b0 : sat_seen_r;
        n_r        <= PW'(n_new);
        t_r        <= '0;
        vnew_r     <= vwr;
        vrd_r      <= vnew_r;    // previous newest is run position one
        hrd_r      <= hnew_dec;
      end
      if (state_r == ST_INIT) begin
        hrd_r <= hrd_dec;
      end
      if (state_r == ST_LOOP) begin
        t_r   <= t_r + PW'(1);
        vrd_r <= vrd_dec;
        hrd_r <= hrd_dec;
      end
      if ((state_r == ST_FINISH) && finish_go) begin
        hnew_r      <= hwr;
        sat_seen_r  <= fin_sat;
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      v_r <= in_if.value;
    end
    if ((state_r == ST_FINISH) && finish_go) begin
      out_sum_r <= fin_best;
      out_sat_r <= fin_sat;
    end
  end

  assign cfg_if.ready     = rst_n;
  assign out_if.valid     = out_valid_r;
  assign out_if.best_sum  = out_sum_r;
  assign out_if.saturated = out_sat_r;

  // last values, circular, newest at vnew_r
  msbrs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (VDEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (vwr),
    .wdata (in_if.value),
    .raddr (vrd_r),
    .rdata (vdata)
  );

  // last prefix optima, circular, newest at hnew_r
  msbrs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (HDEPTH)
  ) u_best_ram (
    .clk   (clk),
    .we    ((state_r == ST_FINISH) && finish_go),
    .waddr (hwr),
    .wdata (fin_best),
    .raddr (hraddr),
    .rdata (hdata)
  );

  msbrs_step #(
    .MAX_RUN (MAX_RUN)
  ) u_step (
    .clk        (clk),
    .ctl        (ctl),
    .cur_value  (v_r),
    .old_value  (vdata),
    .hist_best  (hdata),
    .final_best (fin_best),
    .final_sat  (fin_sat)
  );

endmodule
